// ===== hdl/scoe_pkg.sv =====
// Package for the shift chain output expander.
// Holds command codes, controller states, control struct and byte encoders.
// No dependencies.
`default_nettype none

package scoe_pkg;

    localparam logic [1:0] CMD_MUX       = 2'd0;
    localparam logic [1:0] CMD_LINE      = 2'd1;
    localparam logic [1:0] CMD_INDICATOR = 2'd2;
    localparam logic [1:0] CMD_REFRESH   = 2'd3;

    localparam int IND_CMP_W = 3;

    localparam logic [7:0] MUX_NONE   = 8'h88;
    localparam logic [7:0] MUX_LOW    = 8'h80;
    localparam logic [7:0] MUX_HIGH   = 8'h08;
    localparam logic [7:0] CTRL_RESET = 8'b0000_0111;
    localparam logic [7:0] MUX_RESET  = 8'b1000_1000;
    localparam logic [7:0] IND_RESET  = 8'hff;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_LATCH,
        ST_ERROR
    } state_t;

    typedef struct packed {
        logic rotate;
        logic out_load;
    } ctl_t;

    function automatic logic [7:0] mux_code(input logic [4:0] ch);
        logic [2:0] sel;
        logic [7:0] code;
        sel = 3'(ch - 5'd1);
        if (ch == 5'd0) begin
            code = MUX_NONE;
        end
        else if (ch <= 5'd8) begin
            code = MUX_LOW | {5'b0, sel};
        end
        else begin
            code = MUX_HIGH | {1'b0, sel, 4'b0};
        end
        return code;
    endfunction

    function automatic logic [7:0] set_line(input logic [7:0] value,
                                            input logic [2:0] idx,
                                            input logic       level);
        logic [7:0] result;
        result      = value;
        result[idx] = level;
        return result;
    endfunction

    function automatic logic [7:0] reset_byte(input int idx, input int nbytes);
        logic [7:0] result;
        if (idx == nbytes - 1) begin
            result = MUX_RESET;
        end
        else if (idx == nbytes - 2) begin
            result = CTRL_RESET;
        end
        else begin
            result = IND_RESET;
        end
        return result;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/scoe_cell.sv =====
// One byte cell of the shadow image ring.
// Loads a new byte or rotates left, taking the next cell's top bit. Uses scoe_pkg.
`default_nettype none

module scoe_cell #(
    parameter logic [7:0] RESET_VAL = 8'hff
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       load,
    input  wire logic [7:0] load_val,
    input  wire logic       rotate,
    input  wire logic       shift_in,
    output logic [7:0]      value
);
    import scoe_pkg::*;

    logic [7:0] value_reg;
    logic [7:0] value_next;

    always_comb
    begin
        value_next = value_reg;
        if (load) begin
            value_next = load_val;
        end
        else if (rotate) begin
            value_next = {value_reg[6:0], shift_in};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            value_reg <= RESET_VAL;
        end
        else begin
            value_reg <= value_next;
        end
    end

    assign value = value_reg;

endmodule

`default_nettype wire

// ===== hdl/scoe_ctrl.sv =====
// Sequencer of the shift chain output expander; a bad request gets one error result.
// Steps the ring through one full turn, then the latch result; owns the output register.
`default_nettype none

module scoe_ctrl #(
    parameter int BITS = 40
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       bad,
    input  wire logic       head_bit,
    input  wire logic       out_ready,
    output logic            in_ready,
    output scoe_pkg::ctl_t  ctl,
    output logic            out_valid,
    output logic            out_data,
    output logic            out_latch,
    output logic            out_bad,
    output logic            out_last
);
    import scoe_pkg::*;

    localparam int CNT_W = $clog2(BITS);

    state_t     state_reg;
    state_t     state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic       valid_reg;
    logic       valid_next;
    logic       data_reg;
    logic       data_next;
    logic       latch_reg;
    logic       latch_next;
    logic       bad_reg;
    logic       bad_next;
    logic       last_reg;
    logic       last_next;
    logic       out_free;
    logic       cnt_end;

    assign out_free = !valid_reg || out_ready;
    assign cnt_end  = (cnt_reg == CNT_W'(BITS - 1));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid) begin
                    state_next = bad ? ST_ERROR : ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                if (out_free && cnt_end) begin
                    state_next = ST_LATCH;
                end
            end
            ST_LATCH:
            begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_ERROR:
            begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        ctl.rotate   = 1'b0;
        ctl.out_load = 1'b0;
        cnt_next     = cnt_reg;
        data_next    = data_reg;
        latch_next   = latch_reg;
        bad_next     = bad_reg;
        last_next    = last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cnt_next = '0;
            end
            ST_SHIFT:
            begin
                if (out_free) begin
                    ctl.rotate   = 1'b1;
                    ctl.out_load = 1'b1;
                    cnt_next     = cnt_reg + 1'b1;
                    data_next    = head_bit;
                    latch_next   = 1'b0;
                    bad_next     = 1'b0;
                    last_next    = 1'b0;
                end
            end
            ST_LATCH:
            begin
                if (out_free) begin
                    ctl.out_load = 1'b1;
                    data_next    = 1'b0;
                    latch_next   = 1'b1;
                    bad_next     = 1'b0;
                    last_next    = 1'b1;
                end
            end
            ST_ERROR:
            begin
                if (out_free) begin
                    ctl.out_load = 1'b1;
                    data_next    = 1'b0;
                    latch_next   = 1'b0;
                    bad_next     = 1'b1;
                    last_next    = 1'b1;
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
        if (ctl.out_load) begin
            valid_next = 1'b1;
        end
        else if (out_ready) begin
            valid_next = 1'b0;
        end
        else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg  <= data_next;
        latch_reg <= latch_next;
        bad_reg   <= bad_next;
        last_reg  <= last_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_latch = latch_reg;
    assign out_bad   = bad_reg;
    assign out_last  = last_reg;

endmodule

`default_nettype wire

// ===== hdl/shift_chain_output_expander_top.sv =====
// Top level of the shift chain output expander: a ring of byte cells and its sequencer.
// Depends on scoe_pkg, scoe_cell and scoe_ctrl.
//
// Channel   Direction  Payload                                            Ends run
// s_axis    in         tuser: command; tdata: channel, line, level,       -
//                      indicator address, indicator data
// m_axis    out        tdata: serial_data; tuser: latch_strobe, bad_req   tlast
//
// A command is accepted and updates the image, then the ring turns once with one output
// per image bit, and the latch result comes last.
// A bad indicator address gives one result.
// The ring advances only when the output register is free, so stalls just pause it.
// Reset loads the image ff..ff 07 88 and empties the output register.
`default_nettype none

module shift_chain_output_expander_top #(
    parameter int CHAIN_BYTES = 5
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [4:0] mux_channel, [7:5] line_index, [8] line_level,
    // [10:9] indicator_address, [18:11] indicator_data, [23:19] zero
    input  wire logic [23:0] s_axis_tdata,
    // [1:0] command
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [0] serial_data, [7:1] zero
    output logic [7:0]       m_axis_tdata,
    // [0] latch_strobe, [1] bad_request
    output logic [1:0]       m_axis_tuser,
    output logic             m_axis_tlast
);
    import scoe_pkg::*;

    localparam int BITS = 8 * CHAIN_BYTES;

    logic [1:0]           command;
    logic [4:0]           mux_channel;
    logic [2:0]           line_index;
    logic                 line_level;
    logic [1:0]           indicator_address;
    logic [7:0]           indicator_data;
    logic [IND_CMP_W-1:0] addr_ext;
    logic                 fire;
    logic                 bad;
    ctl_t                 ctl;
    logic [7:0]           cell_val  [CHAIN_BYTES];
    logic [7:0]           load_val  [CHAIN_BYTES];
    logic                 load_en   [CHAIN_BYTES];
    logic                 out_data;
    logic                 out_latch;
    logic                 out_bad;

    assign command           = s_axis_tuser;
    assign mux_channel       = s_axis_tdata[4:0];
    assign line_index        = s_axis_tdata[7:5];
    assign line_level        = s_axis_tdata[8];
    assign indicator_address = s_axis_tdata[10:9];
    assign indicator_data    = s_axis_tdata[18:11];
    assign addr_ext          = {1'b0, indicator_address};

    assign fire = s_axis_tvalid && s_axis_tready;
    assign bad  = (command == CMD_INDICATOR)
               && (addr_ext >= IND_CMP_W'(CHAIN_BYTES - 2));

    for (genvar i = 0; i < CHAIN_BYTES; i++) begin : g_cell
        if (i == CHAIN_BYTES - 1) begin : g_mux
            assign load_en[i]  = fire && (command == CMD_MUX);
            assign load_val[i] = mux_code(mux_channel);
        end
        else if (i == CHAIN_BYTES - 2) begin : g_line
            assign load_en[i]  = fire && (command == CMD_LINE);
            assign load_val[i] = set_line(cell_val[i], line_index, line_level);
        end
        else begin : g_ind
            assign load_en[i]  = fire && (command == CMD_INDICATOR) && !bad
                              && (addr_ext == IND_CMP_W'(CHAIN_BYTES - 3 - i));
            assign load_val[i] = indicator_data;
        end

        scoe_cell #(
            .RESET_VAL (reset_byte(i, CHAIN_BYTES))
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .load     (load_en[i]),
            .load_val (load_val[i]),
            .rotate   (ctl.rotate),
            .shift_in (cell_val[(i + 1) % CHAIN_BYTES][7]),
            .value    (cell_val[i])
        );
    end

    scoe_ctrl #(
        .BITS (BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .bad       (bad),
        .head_bit  (cell_val[0][7]),
        .out_ready (m_axis_tready),
        .in_ready  (s_axis_tready),
        .ctl       (ctl),
        .out_valid (m_axis_tvalid),
        .out_data  (out_data),
        .out_latch (out_latch),
        .out_bad   (out_bad),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {7'b0, out_data};
    assign m_axis_tuser = {out_bad, out_latch};

`ifndef SYNTHESIS
    a_bad_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast && !m_axis_tdata[0])
        else $error("error transaction must be last with data low");

    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> (m_axis_tuser[0] ^ m_axis_tuser[1]))
        else $error("last transaction must be either latch or error");

    a_no_rotate_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> !ctl.rotate)
        else $error("image rotated while a command was accepted");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.out_load |=> m_axis_tvalid)
        else $error("output register load lost");
`endif

endmodule

`default_nettype wire

// ===== tb/shift_chain_output_expander_top_test.sv =====
// Self-checking testbench for the shift chain output expander: a directed table, then random commands.
// A local model of the image predicts each serial bit, latch strobe and error transaction.
// Depends on scoe_pkg and shift_chain_output_expander_top.
`default_nettype none

module shift_chain_output_expander_top_test;

    import scoe_pkg::*;

    localparam int CHAIN_BYTES    = 5;
    localparam int IMG_W          = CHAIN_BYTES * 8;
    localparam int RANDOM_ITEMS   = 410;
    localparam int DIRECTED_ROWS  = 20;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 100;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [4:0]       channel;
        logic [2:0]       line;
        logic             level;
        logic [1:0]       addr;
        logic [7:0]       data;
        logic             typed;
        logic             reject;
        logic [IMG_W-1:0] image;
    } cmd_row_t;

    typedef struct packed {
        logic data_bit;
        logic strobe;
        logic bad;
        logic tail;
    } shift_beat_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    logic [7:0]  chain_image [CHAIN_BYTES];
    shift_beat_t pending_beats [$];
    cmd_row_t    directed_rows [DIRECTED_ROWS];

    int mismatches;
    int beats_seen;
    int rejected_count;
    int cmd_count [4];
    int idle_cycles;
    bit calm_phase;

    shift_chain_output_expander_top #(
        .CHAIN_BYTES(CHAIN_BYTES)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic logic [7:0] encode_mux(input logic [4:0] ch);
        logic [2:0] low3;
        low3 = ch[2:0] - 3'd1;
        if (ch == 5'd0)
        begin
            return MUX_NONE;
        end
        else if (ch <= 5'd8)
        begin
            return MUX_LOW | {5'b0, low3};
        end
        return MUX_HIGH | {1'b0, low3, 4'b0};
    endfunction

    function automatic logic [IMG_W-1:0] image_bits();
        logic [IMG_W-1:0] flat;
        for (int i = 0; i < CHAIN_BYTES; i++)
        begin
            flat[IMG_W-1-8*i -: 8] = chain_image[i];
        end
        return flat;
    endfunction

    task automatic queue_shift(input logic [IMG_W-1:0] img);
        for (int i = IMG_W - 1; i >= 0; i--)
        begin
            pending_beats.push_back('{img[i], 1'b0, 1'b0, 1'b0});
        end
        pending_beats.push_back('{1'b0, 1'b1, 1'b0, 1'b1});
    endtask

    task automatic apply_command(input cmd_row_t r);
        logic [7:0] ctl;
        bit         rejected;
        rejected = 1'b0;
        cmd_count[r.cmd]++;
        case (r.cmd)
            CMD_MUX:
            begin
                chain_image[CHAIN_BYTES-1] = encode_mux(r.channel);
            end
            CMD_LINE:
            begin
                ctl = chain_image[CHAIN_BYTES-2];
                ctl[r.line] = r.level;
                chain_image[CHAIN_BYTES-2] = ctl;
            end
            CMD_INDICATOR:
            begin
                if (int'(r.addr) >= CHAIN_BYTES - 2)
                begin
                    rejected = 1'b1;
                end
                else
                begin
                    chain_image[CHAIN_BYTES-3-int'(r.addr)] = r.data;
                end
            end
            default:
            begin
            end
        endcase
        if (rejected)
        begin
            rejected_count++;
        end
        if (r.typed ? r.reject : rejected)
        begin
            pending_beats.push_back('{1'b0, 1'b0, 1'b1, 1'b1});
        end
        else
        begin
            queue_shift(r.typed ? r.image : image_bits());
        end
    endtask

    task automatic send_row(input cmd_row_t r);
        int gap;
        gap = calm_phase ? 0 : $urandom_range(0, 3);
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= r.cmd;
        s_axis_tdata  <= {5'b0, r.data, r.addr, r.level, r.line, r.channel};
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        apply_command(r);
    endtask

    function automatic cmd_row_t random_row();
        cmd_row_t r;
        r = '0;
        r.cmd   = 2'($urandom_range(0, 3));
        r.line  = 3'($urandom_range(0, 7));
        r.level = 1'($urandom_range(0, 1));
        r.data  = 8'($urandom_range(0, 255));
        r.addr  = ($urandom_range(0, 99) < 15) ? 2'd3 : 2'($urandom_range(0, 2));
        if ($urandom_range(0, 99) < 80)
        begin
            r.channel = 5'($urandom_range(0, 16));
        end
        else
        begin
            r.channel = 5'($urandom_range(17, 31));
        end
        return r;
    endfunction

    task automatic check_beat();
        shift_beat_t got;
        shift_beat_t want;
        got = '{m_axis_tdata[0], m_axis_tuser[0], m_axis_tuser[1], m_axis_tlast};
        beats_seen++;
        if (pending_beats.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("Unexpected transaction: data %0b strobe %0b bad %0b last %0b",
                         got.data_bit, got.strobe, got.bad, got.tail);
            end
        end
        else
        begin
            want = pending_beats.pop_front();
            if (got != want)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("Mismatch at transaction %0d: data %0b/%0b strobe %0b/%0b bad %0b/%0b last %0b/%0b (expected/actual)",
                             beats_seen, want.data_bit, got.data_bit, want.strobe, got.strobe,
                             want.bad, got.bad, want.tail, got.tail);
                end
            end
        end
    endtask

    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = calm_phase ? 0 : $urandom_range(0, 3);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
            begin
                @(posedge clk);
            end
            check_beat();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles + 1 >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog expired with %0d transactions outstanding",
                         pending_beats.size());
                $display("Verification failed");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial
    begin
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = '0;
        rst_n          = 1'b0;
        mismatches     = 0;
        beats_seen     = 0;
        rejected_count = 0;
        idle_cycles    = 0;
        calm_phase     = 1'b0;
        cmd_count      = '{0, 0, 0, 0};
        for (int i = 0; i < CHAIN_BYTES; i++)
        begin
            chain_image[i] = IND_RESET;
        end
        chain_image[CHAIN_BYTES-2] = CTRL_RESET;
        chain_image[CHAIN_BYTES-1] = MUX_RESET;

        directed_rows = '{
            '{CMD_REFRESH,   5'd0,  3'd0, 1'b0, 2'd0, 8'h00, 1'b1, 1'b0, 40'hff_ff_ff_07_88},
            '{CMD_MUX,       5'd0,  3'd0, 1'b0, 2'd0, 8'h00, 1'b1, 1'b0, 40'hff_ff_ff_07_88},
            '{CMD_MUX,       5'd1,  3'd0, 1'b0, 2'd0, 8'h00, 1'b1, 1'b0, 40'hff_ff_ff_07_80},
            '{CMD_MUX,       5'd8,  3'd0, 1'b0, 2'd0, 8'h00, 1'b1, 1'b0, 40'hff_ff_ff_07_87},
            '{CMD_MUX,       5'd9,  3'd0, 1'b0, 2'd0, 8'h00, 1'b1, 1'b0, 40'hff_ff_ff_07_08},
            '{CMD_MUX,       5'd16, 3'd0, 1'b0, 2'd0, 8'h00, 1'b1, 1'b0, 40'hff_ff_ff_07_78},
            '{CMD_MUX,       5'd17, 3'd0, 1'b0, 2'd0, 8'h00, 1'b0, 1'b0, 40'h0},
            '{CMD_MUX,       5'd31, 3'd0, 1'b0, 2'd0, 8'h00, 1'b0, 1'b0, 40'h0},
            '{CMD_LINE,      5'd0,  3'd0, 1'b0, 2'd0, 8'h00, 1'b0, 1'b0, 40'h0},
            '{CMD_LINE,      5'd0,  3'd7, 1'b1, 2'd0, 8'h00, 1'b0, 1'b0, 40'h0},
            '{CMD_LINE,      5'd0,  3'd5, 1'b1, 2'd0, 8'h00, 1'b0, 1'b0, 40'h0},
            '{CMD_LINE,      5'd0,  3'd5, 1'b0, 2'd0, 8'h00, 1'b0, 1'b0, 40'h0},
            '{CMD_INDICATOR, 5'd0,  3'd0, 1'b0, 2'd0, 8'h00, 1'b0, 1'b0, 40'h0},
            '{CMD_INDICATOR, 5'd0,  3'd0, 1'b0, 2'd2, 8'hff, 1'b0, 1'b0, 40'h0},
            '{CMD_INDICATOR, 5'd0,  3'd0, 1'b0, 2'd1, 8'ha5, 1'b0, 1'b0, 40'h0},
            '{CMD_INDICATOR, 5'd0,  3'd0, 1'b0, 2'd3, 8'h5a, 1'b1, 1'b1, 40'h0},
            '{CMD_REFRESH,   5'd0,  3'd0, 1'b0, 2'd0, 8'h00, 1'b0, 1'b0, 40'h0},
            '{CMD_REFRESH,   5'd31, 3'd7, 1'b1, 2'd3, 8'hff, 1'b0, 1'b0, 40'h0},
            '{CMD_INDICATOR, 5'd31, 3'd7, 1'b1, 2'd3, 8'h00, 1'b1, 1'b1, 40'h0},
            '{CMD_MUX,       5'd5,  3'd2, 1'b1, 2'd1, 8'h3c, 1'b0, 1'b0, 40'h0}
        };

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            send_row(directed_rows[i]);
        end
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            calm_phase = (i % 64) < 12;
            send_row(random_row());
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        calm_phase = 1'b0;

        while (pending_beats.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Commands: %0d mux, %0d line, %0d indicator (%0d rejected), %0d refresh",
                 cmd_count[CMD_MUX], cmd_count[CMD_LINE], cmd_count[CMD_INDICATOR],
                 rejected_count, cmd_count[CMD_REFRESH]);
        $display("Output transactions checked: %0d, mismatches: %0d", beats_seen, mismatches);
        if (mismatches == 0 && pending_beats.size() == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
